// ----- hdl/modular_exponentiation_assert.svh -----
// Assertion helpers shared by the RTL. Clock is clk, reset is rst.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Same-cycle implication.
`define MEXP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mexp_pkg.sv -----
package mexp_pkg;

  localparam int BASE_W       = 31;
  localparam int RES_W        = 31;
  localparam int EXP_BITS_DEF = 63;
  localparam int MOD_BITS_DEF = 31;
  localparam longint MOD_RESET = 64'd1000000007;

endpackage

// ----- hdl/mexp_mulred.sv -----
// One bit-serial interleaved modular multiply: p = 2p + y_bit*x, reduced
// by m. With p, x < m the sum stays below 3m, so one of three candidates
// is the reduced value.
module mexp_mulred #(
  parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
  input  logic                clk,
  input  logic                clear,
  input  logic                step,
  input  logic [MOD_BITS-1:0] x,
  input  logic                y_bit,
  input  logic [MOD_BITS-1:0] m,
  output logic [MOD_BITS-1:0] p
);

  localparam int W = MOD_BITS + 2;

  logic [W-1:0]        sum;
  logic [W-1:0]        m1;
  logic [W-1:0]        m2;
  logic [MOD_BITS-1:0] p_next;

  always_comb begin
    m1  = W'(m);
    m2  = W'(m) << 1;
    sum = (W'(p) << 1) + (y_bit ? W'(x) : '0);
    if (sum >= m2) begin
      p_next = MOD_BITS'(sum - m2);
    end else if (sum >= m1) begin
      p_next = MOD_BITS'(sum - m1);
    end else begin
      p_next = MOD_BITS'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      p <= '0;
    end else if (step) begin
      p <= p_next;
    end
  end

endmodule

// ----- hdl/modular_exponentiation.sv -----
// A modulus of 0 or 1 sends an item straight to FINISH with a zero result.
// Otherwise the base is first reduced by the modulus, then each exponent
// bit up to the highest set one passes through two serial multipliers.
// One item at a time; a finished result waits in the output register while
// the next is taken. Sync reset: modulus 1000000007, empty.
module modular_exponentiation #(
  parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF,
  parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mexp_pkg::BASE_W-1:0] base_value,
  input  logic [EXP_BITS-1:0]         power,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mexp_pkg::RES_W-1:0]  residue,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [MOD_BITS-1:0]         modulus
);

  import mexp_pkg::*;

  localparam int CNT_W = $clog2(BASE_W);

  typedef enum logic [2:0] {IDLE, REDUCE, LOAD, MUL, UPD, FINISH} state_t;

  state_t              state;
  logic [MOD_BITS-1:0] mod_value;
  logic [MOD_BITS-1:0] acc;
  logic [MOD_BITS-1:0] base_r;
  logic [EXP_BITS-1:0] exp;
  logic [BASE_W-1:0]   yshift;
  logic [CNT_W-1:0]    cnt;

  logic                unit_clear;
  logic                unit_step;
  logic [MOD_BITS-1:0] xa;
  logic [MOD_BITS-1:0] pa;
  logic [MOD_BITS-1:0] pb;
  logic [BASE_W-1:0]   ya_aligned;
  logic [BASE_W-1:0]   yb_aligned;

  assign in_stall   = (state != IDLE);
  // no modulus write in the cycle an item is taken
  assign cfg_ready  = (state == IDLE) && !in_valid;
  assign unit_clear = (state == IDLE && in_valid) || state == LOAD || state == UPD;
  assign unit_step  = (state == REDUCE) || (state == MUL);
  // base reduction is a multiply by one
  assign xa         = (state == REDUCE) ? MOD_BITS'(1) : acc;
  // serial operand runs MSB first from the top of the shift register
  assign ya_aligned = BASE_W'(pa) << (BASE_W - MOD_BITS);
  assign yb_aligned = BASE_W'(pb) << (BASE_W - MOD_BITS);

  // acc * base (also base reduction)
  mexp_mulred #(.MOD_BITS(MOD_BITS)) u_mul_acc (
    .clk   (clk),
    .clear (unit_clear),
    .step  (unit_step),
    .x     (xa),
    .y_bit (yshift[BASE_W-1]),
    .m     (mod_value),
    .p     (pa)
  );

  // base * base
  mexp_mulred #(.MOD_BITS(MOD_BITS)) u_mul_sq (
    .clk   (clk),
    .clear (unit_clear),
    .step  (unit_step),
    .x     (base_r),
    .y_bit (yshift[BASE_W-1]),
    .m     (mod_value),
    .p     (pb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      mod_value <= MOD_BITS'(MOD_RESET);
    end else begin
      if (cfg_valid && cfg_ready) begin
        mod_value <= modulus;
      end
      if (out_valid && !out_stall && state != FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            exp    <= power;
            yshift <= base_value;
            cnt    <= CNT_W'(BASE_W - 1);
            if (mod_value > MOD_BITS'(1)) begin
              acc   <= MOD_BITS'(1);
              state <= REDUCE;
            end else begin
              acc   <= '0;
              state <= FINISH;
            end
          end
        end
        REDUCE: begin
          yshift <= yshift << 1;
          cnt    <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= LOAD;
          end
        end
        LOAD: begin
          base_r <= pa;
          yshift <= ya_aligned;
          cnt    <= CNT_W'(MOD_BITS - 1);
          state  <= (exp == '0) ? FINISH : MUL;
        end
        MUL: begin
          yshift <= yshift << 1;
          cnt    <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= UPD;
          end
        end
        UPD: begin
          if (exp[0]) begin
            acc <= pa;
          end
          base_r <= pb;
          yshift <= yb_aligned;
          exp    <= exp >> 1;
          cnt    <= CNT_W'(MOD_BITS - 1);
          state  <= ((exp >> 1) == '0) ? FINISH : MUL;
        end
        FINISH: begin
          if (!out_valid || !out_stall) begin
            residue   <= RES_W'(acc);
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`include "modular_exponentiation_assert.svh"

  `MEXP_ASSERT_NOW(a_prod_reduced, state == UPD, pa < mod_value && pb < mod_value, "bad product")
  `MEXP_ASSERT_NOW(a_acc_reduced, state == MUL, acc < mod_value, "accumulator not reduced")
  `MEXP_ASSERT_NEXT(a_start, in_valid && !in_stall, state == REDUCE || state == FINISH, "no start")
  `MEXP_ASSERT_NOW(a_upd_after_mul, state == UPD, $past(state) == MUL, "no multiply pass")

endmodule

// ----- sim/modexp_checker.sv -----
module modexp_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [mexp_pkg::BASE_W-1:0]     base_value,
  input  logic [mexp_pkg::EXP_BITS_DEF-1:0] power,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [mexp_pkg::RES_W-1:0]      residue,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [mexp_pkg::MOD_BITS_DEF-1:0] modulus,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MW = mexp_pkg::MOD_BITS_DEF;
  localparam int EW = mexp_pkg::EXP_BITS_DEF;
  localparam int RW = mexp_pkg::RES_W;

  logic [MW-1:0] mod_now;
  logic [RW-1:0] residues_due[$];
  logic [RW-1:0] want;
  int            fails = 0;

  // right-to-left square-and-multiply; every product fits in 64 bits
  function automatic logic [RW-1:0] pow_mod(input logic [mexp_pkg::BASE_W-1:0] b,
                                            input logic [EW-1:0] e,
                                            input logic [MW-1:0] m);
    bit [63:0] acc;
    bit [63:0] sq;
    bit [63:0] mm;
    if (m == '0) return '0;
    mm  = 64'(m);
    acc = 64'd1 % mm;
    sq  = 64'(b) % mm;
    for (int i = 0; i < EW; i++) begin
      if (e[i]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
    end
    return acc[RW-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      mod_now = MW'(mexp_pkg::MOD_RESET);
      residues_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) mod_now = modulus;
      // retire before pushing, so a result can never match its own item
      if (out_valid && !out_stall) begin
        if (residues_due.size() == 0) begin
          $error("residue %0d arrived with no item outstanding", residue);
          fails++;
        end else begin
          want = residues_due.pop_front();
          if (residue !== want) begin
            $error("residue mismatch: expected %0d, actual %0d", want, residue);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall)
        residues_due.push_back(pow_mod(base_value, power, mod_now));
    end
    fail_count <= fails;
    pending    <= residues_due.size();
  end

endmodule

// ----- sim/modular_exponentiation_tb.sv -----
module modular_exponentiation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BW = mexp_pkg::BASE_W;
  localparam int EW = mexp_pkg::EXP_BITS_DEF;
  localparam int MW = mexp_pkg::MOD_BITS_DEF;
  localparam int RW = mexp_pkg::RES_W;

  localparam logic [BW-1:0] BASE_MAX = '1;
  localparam logic [EW-1:0] POW_MAX  = '1;
  localparam logic [MW-1:0] MOD_MAX  = '1;
  localparam logic [MW-1:0] MOD_DEF  = MW'(mexp_pkg::MOD_RESET);

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [BW-1:0] base_value = '0;
  logic [EW-1:0] power = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [RW-1:0] residue;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [MW-1:0] cfg_modulus = '0;

  int fail_count;
  int pending;
  int stall_left = 0;
  logic calm = 1'b0;
  bit   quiet_now = 1'b0;

  always #10 clk = ~clk;

  modular_exponentiation DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .base_value (base_value),
    .power      (power),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .residue    (residue),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .modulus    (cfg_modulus)
  );

  modexp_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .base_value (base_value),
    .power      (power),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .residue    (residue),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .modulus    (cfg_modulus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [EW-1:0] pick_power();
    logic [63:0] r;
    int          w;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return EW'($urandom_range(0, 20));
      1: return r[EW-1:0];
      2: begin
        w = $urandom_range(1, EW);
        return r[EW-1:0] & ((EW'(1) << w) - EW'(1));
      end
      default: return EW'(1) << $urandom_range(0, EW - 1);
    endcase
  endfunction

  function automatic logic [BW-1:0] pick_base(input logic [MW-1:0] m);
    case ($urandom_range(0, 4))
      0: return BW'($urandom);
      1: return BW'($urandom_range(0, 3));
      2: return BW'(m - 1'b1);
      3: return BW'(m + MW'($urandom_range(0, 1)));
      default: return (m == '0) ? BW'($urandom) : BW'($urandom % m);
    endcase
  endfunction

  // receiver stall, in runs of random length
  always @(negedge clk) begin
    if (rst || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 99) < 35);
      stall_left <= idle_len();
    end
  end

  task automatic send_item(input logic [BW-1:0] b, input logic [EW-1:0] e);
    int gap;
    gap = quiet_now ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    base_value <= b;
    power      <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off until every outstanding item has produced its residue
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic load_modulus(input logic [MW-1:0] m);
    @(negedge clk);
    cfg_valid   <= 1'b1;
    cfg_modulus <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [MW-1:0] m, input int n, input bit quiet);
    drain();
    load_modulus(m);
    calm      <= quiet;
    quiet_now = quiet;
    repeat (n) send_item(pick_base(m), pick_power());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset modulus, never written yet
    send_item('0, '0);
    send_item('0, EW'(1));
    send_item('0, POW_MAX);
    send_item(BASE_MAX, '0);
    send_item(BASE_MAX, POW_MAX);
    send_item(BW'(1), POW_MAX);
    send_item(BW'(2), EW'(1));
    send_item(BW'(MOD_DEF), EW'(5));
    send_item(BW'(MOD_DEF - 1'b1), EW'(2));
    send_item(BW'(MOD_DEF + 1'b1), POW_MAX);
    send_item(BW'(3), EW'(1) << (EW - 1));
    send_item(BASE_MAX, EW'(1));

    // modulus of one: everything reduces to zero
    drain();
    load_modulus(MW'(1));
    send_item('0, '0);
    send_item(BASE_MAX, POW_MAX);
    send_item(BW'(5), '0);

    // zero modulus: no reduction, residue forced to zero
    drain();
    load_modulus('0);
    send_item('0, '0);
    send_item(BW'(7), EW'(3));
    send_item(BASE_MAX, POW_MAX);

    // largest modulus; base equal to it reduces to zero
    drain();
    load_modulus(MOD_MAX);
    send_item(BASE_MAX, POW_MAX);
    send_item(BASE_MAX - 1'b1, EW'(2));
    send_item(BW'(2), EW'(30));
    send_item(BW'(2), EW'(31));

    run_phase(MOD_DEF, 15, 1'b0);
    run_phase(MW'(2), 13, 1'b0);
    run_phase(MW'($urandom_range(3, 1000)), 15, 1'b1);
    run_phase(MW'(1), 8, 1'b0);
    run_phase(MW'($urandom) | MW'(32'h4000_0000), 17, 1'b0);
    run_phase(MOD_MAX, 15, 1'b0);
    run_phase('0, 8, 1'b1);
    run_phase(MW'($urandom_range(2, 32'h7FFF_FFFF)), 17, 1'b0);
    run_phase(MW'(65536), 10, 1'b0);

    drain();
    repeat (2100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("modular_exponentiation_tb passed");
    end else begin
      $display("modular_exponentiation_tb failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("modular_exponentiation_tb failed");
    $finish;
  end

endmodule
